/* rtl/swa_pkg.sv */
// Shared constants, types and helpers of the staggered window averager.
package swa_pkg;

  localparam int MAX_TAPS      = 1024;
  localparam int NUM_STAGES    = 4;
  localparam int SAMPLE_BITS   = 16;
  localparam int WEIGHT_BITS   = 18;
  localparam int ACC_BITS      = 48;
  localparam int FRAC_BITS     = WEIGHT_BITS - 1;
  localparam int PROD_BITS     = SAMPLE_BITS + WEIGHT_BITS;
  localparam int TAP_BITS      = $clog2(MAX_TAPS);
  localparam int CNT_BITS      = $clog2(MAX_TAPS + 1);
  localparam int STAGE_BITS    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int SEQ_BITS      = $clog2(NUM_STAGES + 2);

  localparam int IN_FIELD_BITS = SAMPLE_BITS + TAP_BITS + WEIGHT_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int WIDX_LSB      = SAMPLE_BITS;
  localparam int WVAL_LSB      = SAMPLE_BITS + TAP_BITS;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic REG_TAP_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } seq_state_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic [ACC_BITS-1:0]           acc_t;
  typedef logic [TAP_BITS-1:0]           tap_t;
  typedef logic [CNT_BITS-1:0]           count_t;

  // start position of stage s for a window of n taps
  function automatic tap_t stage_start(int s, count_t n);
    logic [CNT_BITS+STAGE_BITS-1:0] m;
    m = (CNT_BITS + STAGE_BITS)'(s) * (CNT_BITS + STAGE_BITS)'(n);
    return TAP_BITS'(m / NUM_STAGES);
  endfunction

endpackage

/* rtl/staggered_window_average.sv */
// Staggered window averager: sequencer, stage state, config port and output register.
// A sample transfer, once accepted, has the one shared multiply-accumulate visit the stages
// one per cycle through a two-stage pipe (weight read, product), after which the held sum is
// rounded and saturated into the output register, which sets the result valid. The input is
// not ready during that time and takes the next transfer in the cycle after the result is
// loaded, so a new sample is never taken before the last one is through; a result still
// waiting on the output holds the sequencer until it leaves. A weight write transfer is taken
// while idle and gives no result. Writing tap_count (byte address 0, clamped to 2..1024)
// clears the stage sums and restarts the stage positions; it must only be done while the
// block is idle. Weights must be written before any sample reads them.
module staggered_window_average (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] sample, [25:16] weight_index, [43:26] weight_value
  input  logic [swa_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // [0] req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] filtered
  output logic [swa_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // [0] updated
  output logic                                m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swa_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [swa_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [swa_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import swa_pkg::*;

  localparam int QUO_BITS = ACC_BITS + 1 - FRAC_BITS;

  seq_state_e state_q, state_d;
  logic [SEQ_BITS-1:0] seq_q, seq_d;
  sample_t sample_q;
  count_t tap_q;
  tap_t pos_q [NUM_STAGES];
  acc_t sum_q [NUM_STAGES];
  acc_t held_q;
  logic v1_q, v2_q, cmp1_q, cmp2_q, done_q;
  logic [STAGE_BITS-1:0] tag1_q, tag2_q;
  logic out_valid_q, out_upd_q;
  sample_t out_data_q;

  logic in_acc, smp_start, wr_weight, issue, load_out, seq_last;
  logic cfg_wr, tap_wr;
  logic [STAGE_BITS-1:0] issue_idx;
  tap_t cur_pos;
  count_t pos_inc, tap_new, wr_val;
  logic complete;
  weight_t rd_weight;
  acc_t sum_new;
  logic signed [ACC_BITS:0] rnd;
  logic [QUO_BITS-1:0] quo;
  sample_t sat_val;

  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign smp_start = in_acc & ~s_axis_tuser;
  assign wr_weight = in_acc & s_axis_tuser;

  assign issue_idx = seq_q[STAGE_BITS-1:0];
  assign seq_last  = (seq_q == SEQ_BITS'(NUM_STAGES + 1));
  assign cur_pos   = pos_q[issue_idx];
  assign pos_inc   = count_t'(cur_pos) + count_t'(1);
  assign complete  = (pos_inc >= tap_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (smp_start) state_d = ST_RUN;
      ST_RUN:   if (seq_last) state_d = ST_FLUSH;
      ST_FLUSH: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    seq_d         = '0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_RUN: begin
        issue = (seq_q < SEQ_BITS'(NUM_STAGES));
        seq_d = seq_q + SEQ_BITS'(1);
      end
      ST_FLUSH: load_out = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seq_q   <= '0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
    end
  end

  swa_weight_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_weight),
    .waddr_i (s_axis_tdata[WVAL_LSB-1:WIDX_LSB]),
    .wdata_i (s_axis_tdata[WVAL_LSB+WEIGHT_BITS-1:WVAL_LSB]),
    .re_i    (issue),
    .raddr_i (cur_pos),
    .rdata_o (rd_weight)
  );

  swa_mac u_mac (
    .clk_i    (clk_i),
    .en_i     (v1_q),
    .weight_i (rd_weight),
    .sample_i (sample_q),
    .sum_i    (sum_q[tag2_q]),
    .sum_o    (sum_new)
  );

  always_ff @(posedge clk_i) begin
    if (smp_start) begin
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      cmp1_q <= 1'b0;
      cmp2_q <= 1'b0;
      tag1_q <= '0;
      tag2_q <= '0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= issue;
      v2_q   <= v1_q;
      cmp1_q <= issue & complete;
      cmp2_q <= cmp1_q;
      tag1_q <= issue_idx;
      tag2_q <= tag1_q;
      if (smp_start) begin
        done_q <= 1'b0;
      end else if (v2_q && cmp2_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign tap_wr = cfg_wr & (paddr[CFG_ADDR_BITS-1:2] == REG_TAP_COUNT);
  assign wr_val = pwdata[CNT_BITS-1:0];

  always_comb begin
    tap_new = wr_val;
    if (wr_val < count_t'(2)) begin
      tap_new = count_t'(2);
    end else if (wr_val > count_t'(MAX_TAPS)) begin
      tap_new = count_t'(MAX_TAPS);
    end
  end

  assign prdata = (paddr[CFG_ADDR_BITS-1:2] == REG_TAP_COUNT) ? CFG_DATA_BITS'(tap_q) : '0;

  // stage state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= count_t'(MAX_TAPS);
      held_q <= '0;
      for (int s = 0; s < NUM_STAGES; s++) begin
        pos_q[s] <= stage_start(s, count_t'(MAX_TAPS));
        sum_q[s] <= '0;
      end
    end else begin
      if (tap_wr) begin
        tap_q <= tap_new;
      end
      if (v2_q && cmp2_q) begin
        held_q <= sum_new;
      end
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (tap_wr) begin
          pos_q[s] <= stage_start(s, tap_new);
          sum_q[s] <= '0;
        end else begin
          if (issue && issue_idx == STAGE_BITS'(s)) begin
            pos_q[s] <= complete ? '0 : pos_inc[TAP_BITS-1:0];
          end
          if (v2_q && tag2_q == STAGE_BITS'(s)) begin
            sum_q[s] <= cmp2_q ? '0 : sum_new;
          end
        end
      end
    end
  end

  // round half up, then saturate
  assign rnd = $signed({held_q[ACC_BITS-1], held_q}) + (ACC_BITS + 1)'(1 << (FRAC_BITS - 1));
  assign quo = rnd[ACC_BITS:FRAC_BITS];

  always_comb begin
    sat_val = quo[SAMPLE_BITS-1:0];
    if (quo[QUO_BITS-1:SAMPLE_BITS-1] != '0 && quo[QUO_BITS-1:SAMPLE_BITS-1] != '1) begin
      sat_val = {quo[QUO_BITS-1], {(SAMPLE_BITS - 1){~quo[QUO_BITS-1]}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= sat_val;
      out_upd_q  <= done_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'(out_data_q);
  assign m_axis_tuser  = out_upd_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !v1_q && !v2_q)
    else $error("pipeline busy while input ready");

  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_t'(pos_q[NUM_STAGES-1]) < tap_q)
    else $error("stage position beyond window");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_q >= count_t'(2) && tap_q <= count_t'(MAX_TAPS))
    else $error("tap count out of range");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid)
    else $error("result load lost");

endmodule

/* rtl/swa_weight_ram.sv */
// Window weight store: one write port, one registered read port.
module swa_weight_ram (
  input  logic            clk_i,
  input  logic            we_i,
  input  swa_pkg::tap_t    waddr_i,
  input  swa_pkg::weight_t wdata_i,
  input  logic            re_i,
  input  swa_pkg::tap_t    raddr_i,
  output swa_pkg::weight_t rdata_o
);
  import swa_pkg::*;

  weight_t mem_q [MAX_TAPS];
  weight_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/swa_mac.sv */
// Shared multiply-accumulate unit: registered product, then 48-bit add.
module swa_mac (
  input  logic            clk_i,
  input  logic            en_i,
  input  swa_pkg::weight_t weight_i,
  input  swa_pkg::sample_t sample_i,
  input  swa_pkg::acc_t    sum_i,
  output swa_pkg::acc_t    sum_o
);
  import swa_pkg::*;

  logic signed [PROD_BITS-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= weight_i * sample_i;
    end
  end

  assign sum_o = sum_i + {{(ACC_BITS - PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

endmodule
